[hw/rtl/stm_pkg.sv]
package stm_pkg;

    localparam int SAMPLE_W = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_WRKEY,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

endpackage

[hw/rtl/stm_alu.sv]
module stm_alu
    import stm_pkg::*;
#(
    parameter int UW = 17
) (
    input  alu_op_t       op,
    input  logic [UW-1:0] a,
    input  logic [UW-1:0] b,
    output logic [UW-1:0] res,
    output logic          borrow
);

    logic [UW:0] full;

    always_comb
    begin
        unique case (op)
            ALU_ADD: full = {1'b0, a} + {1'b0, b};
            ALU_SUB: full = {1'b0, a} - {1'b0, b};
            default: full = '0;
        endcase
        res    = full[UW-1:0];
        // msb of the subtract is the borrow (a < b)
        borrow = (op == ALU_SUB) ? full[UW] : 1'b0;
    end

endmodule

[hw/rtl/stm_store.sv]
module stm_store
    import stm_pkg::*;
#(
    parameter int DEPTH = 30,
    parameter int AW    = 5
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic [SAMPLE_W-1:0] wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output logic [SAMPLE_W-1:0] rd_data
);

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/sorted_trimmed_mean.sv]
// channel  direction  fields        handshake
// sample   in         sample[15:0]  sample_valid / sample_ready
// mean     out        mean[15:0]    mean_valid / mean_ready
//
// each request is inserted into a sorted store by one compare/shift per cycle;
// sample_ready stays low until the insertion loop is done with the sample
// the window-completing sample then adds the summing states, the divide by
// reciprocal multiply and the load of the mean register
// rst_n clears the sequencer, fill count and output valid; the store needs no clear
// a stalled mean only blocks the block when the next window's mean is ready
module sorted_trimmed_mean
    import stm_pkg::*;
#(
    parameter int WINDOW     = 30,
    parameter int TRIM_BELOW = 10,
    parameter int KEEP_COUNT = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                sample_valid,
    output logic                sample_ready,
    output logic [SAMPLE_W-1:0] mean,
    output logic                mean_valid,
    input  logic                mean_ready
);

    localparam int AW      = $clog2(WINDOW);
    localparam int SUM_END = (TRIM_BELOW + KEEP_COUNT < WINDOW) ?
                             (TRIM_BELOW + KEEP_COUNT) : WINDOW;
    localparam int SUM_LEN = (SUM_END > TRIM_BELOW) ? (SUM_END - TRIM_BELOW) : 0;
    localparam int SUM_W   = $clog2(KEEP_COUNT * ((1 << SAMPLE_W) - 1) + 1);
    // exact quotient of any SUM_W-bit sum: ceil(2^(SUM_W+l)/K) with l = ceil(log2 K)
    localparam int     RECIP_SH = SUM_W + $clog2(KEEP_COUNT);
    localparam int     RECIP_W  = SUM_W + 1;
    localparam longint RECIP    = ((longint'(1) << RECIP_SH) + longint'(KEEP_COUNT) - 1)
                                  / longint'(KEEP_COUNT);
    localparam int     PW       = SUM_W + RECIP_W;

    state_t              state_reg, state_next;
    logic [AW-1:0]       fill_reg, fill_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [SAMPLE_W-1:0] key_reg, key_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SAMPLE_W-1:0] mean_reg, mean_next;
    logic                mean_valid_reg, mean_valid_next;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [SAMPLE_W-1:0] wr_data;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [SAMPLE_W-1:0] rd_data;

    alu_op_t             alu_op;
    logic [SUM_W-1:0]    alu_a, alu_b, alu_res;
    logic                alu_borrow;
    logic [RECIP_W-1:0]  recip;
    logic [PW-1:0]       prod;

    stm_store #(
        .DEPTH (WINDOW),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    stm_alu #(
        .UW (SUM_W)
    ) u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .res    (alu_res),
        .borrow (alu_borrow)
    );

    assign recip        = RECIP_W'(RECIP);
    assign prod         = PW'(sum_reg) * PW'(recip);
    assign sample_ready = (state_reg == ST_IDLE);
    assign mean         = mean_reg;
    assign mean_valid   = mean_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            mean_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            mean_valid_reg <= mean_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        key_reg  <= key_next;
        sum_reg  <= sum_next;
        mean_reg <= mean_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        pos_next        = pos_reg;
        key_next        = key_reg;
        sum_next        = sum_reg;
        mean_next       = mean_reg;
        mean_valid_next = mean_valid_reg && !mean_ready;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_data         = key_reg;
        rd_en           = 1'b0;
        rd_addr         = pos_reg - AW'(1);
        alu_op          = ALU_ADD;
        alu_a           = '0;
        alu_b           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    key_next = sample;
                    pos_next = fill_reg;
                    if (fill_reg == '0)
                    begin
                        state_next = ST_WRKEY;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = fill_reg - AW'(1);
                        state_next = ST_CMP;
                    end
                end
            end

            ST_CMP:
            begin
                // rd_data holds the entry just below the hole at pos_reg
                alu_op = ALU_SUB;
                alu_a  = SUM_W'(key_reg);
                alu_b  = SUM_W'(rd_data);
                wr_en  = 1'b1;
                if (alu_borrow)
                begin
                    wr_data  = rd_data;
                    pos_next = pos_reg - AW'(1);
                    if (pos_reg == AW'(1))
                    begin
                        state_next = ST_WRKEY;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = pos_reg - AW'(2);
                    end
                end
                else
                begin
                    if (fill_reg == AW'(WINDOW - 1))
                    begin
                        fill_next  = '0;
                        state_next = ST_SUM_RD;
                    end
                    else
                    begin
                        fill_next  = fill_reg + AW'(1);
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_WRKEY:
            begin
                wr_en = 1'b1;
                if (fill_reg == AW'(WINDOW - 1))
                begin
                    fill_next  = '0;
                    state_next = ST_SUM_RD;
                end
                else
                begin
                    fill_next  = fill_reg + AW'(1);
                    state_next = ST_IDLE;
                end
            end

            ST_SUM_RD:
            begin
                sum_next = '0;
                if (SUM_LEN == 0)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(TRIM_BELOW);
                    pos_next   = AW'(TRIM_BELOW);
                    state_next = ST_SUM_ACC;
                end
            end

            ST_SUM_ACC:
            begin
                alu_op   = ALU_ADD;
                alu_a    = sum_reg;
                alu_b    = SUM_W'(rd_data);
                sum_next = alu_res;
                if (pos_reg == AW'(SUM_END - 1))
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = pos_reg + AW'(1);
                    pos_next = pos_reg + AW'(1);
                end
            end

            ST_DIV:
            begin
                // divide by the keep count as multiply by its reciprocal, then shift
                sum_next   = SUM_W'(prod[RECIP_SH +: SAMPLE_W]);
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                if (!mean_valid_reg || mean_ready)
                begin
                    mean_next       = sum_reg[SAMPLE_W-1:0];
                    mean_valid_next = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
